>>> sv/lsbc_pkg.sv
// Package for the LED state and blink controller core.
// Holds word types, command and mode codes, control handshake structs and
// the controller state type. No dependencies.
package lsbc_pkg;

	localparam int IDX_W     = 5;
	localparam int CODE_W    = 3;
	localparam int PACK_LEDS = 18;
	localparam int PACK_W    = PACK_LEDS * CODE_W;
	localparam int PIN_W     = 18;
	localparam int SEL_W     = 6;

	typedef enum logic [2:0] {
		CMD_SET_ONE   = 3'd0,
		CMD_SET_ALL   = 3'd1,
		CMD_FORCE_OFF = 3'd2,
		CMD_FORCE_ON  = 3'd3,
		CMD_TOGGLE    = 3'd4,
		CMD_TICK      = 3'd5,
		CMD_READ      = 3'd6
	} led_cmd_t;

	localparam logic [CODE_W-1:0] CODE_OFF  = 3'd0;
	localparam logic [CODE_W-1:0] CODE_SLOW = 3'd5;
	localparam logic [CODE_W-1:0] CODE_FAST = 3'd6;
	localparam logic [CODE_W-1:0] CODE_ON   = 3'd7;

	typedef struct packed {
		logic [2:0]        command;
		logic [IDX_W-1:0]  led_index;
		logic [CODE_W-1:0] state_code;
		logic              store_code;
		logic              force_flag;
		logic [PACK_W-1:0] all_codes;
	} in_word_t;

	typedef struct packed {
		logic [PIN_W-1:0]  pin_levels;
		logic [CODE_W-1:0] led_code_read;
		logic              state_matches;
	} out_word_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic walk;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic walk_cmd;
		logic last;
		logic out_free;
	} ctl_sts_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_READ
	} ctl_state_t;

	function automatic logic drive_level(input logic [CODE_W-1:0] code, input logic cur);
		logic lvl;
		lvl = cur;
		if (code == CODE_ON) begin
			lvl = 1'b1;
		end else if (code == CODE_OFF) begin
			lvl = 1'b0;
		end
		return lvl;
	endfunction

endpackage

>>> sv/lsbc_ctrl.sv
// Controller state machine of the LED state and blink controller core.
// Sequences accept, single-LED execute, per-LED walk and result load.
// Depends on lsbc_pkg.
module lsbc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lsbc_pkg::ctl_sts_t sts,
	output lsbc_pkg::ctl_cmd_t cmd
);
	import lsbc_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = sts.walk_cmd ? ST_WALK : ST_READ;
			end
			ST_WALK: begin
				if (sts.last) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = !sts.walk_cmd;
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
			end
			ST_READ: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> sv/lsbc_dp.sv
// Datapath of the LED state and blink controller core.
// Holds mode codes, pin levels, force masks, blink phases and the output word.
// Depends on lsbc_pkg.
module lsbc_dp #(
	parameter int LED_COUNT = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsbc_pkg::in_word_t  in_word,
	input  lsbc_pkg::ctl_cmd_t  cmd,
	output lsbc_pkg::ctl_sts_t  sts,
	input  logic                out_stall,
	output logic                out_valid,
	output lsbc_pkg::out_word_t out_word
);
	import lsbc_pkg::*;

	localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	in_word_t          in_q;
	out_word_t         out_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] codes_q [LED_COUNT];
	logic [LED_COUNT-1:0] pins_q;
	logic [LED_COUNT-1:0] off_q;
	logic [LED_COUNT-1:0] on_q;
	logic              slow_q;
	logic              fast_q;
	logic [AW-1:0]     cnt_q;

	logic [IDX_W-1:0]  addr;
	logic [AW-1:0]     pa;
	logic              idx_ok;
	logic [CODE_W-1:0] cur_code;
	logic [CODE_W-1:0] pack_code;
	logic              phase;
	logic              pin_we;
	logic              pin_val;
	logic              code_we;
	logic [CODE_W-1:0] code_val;
	logic [LED_COUNT-1:0] off_d;
	logic [LED_COUNT-1:0] on_d;
	logic              flip;
	logic [PIN_W-1:0]  levels;
	logic [CODE_W-1:0] rb_code;
	out_word_t         out_d;

	always_comb begin
		addr     = cmd.walk ? IDX_W'(cnt_q) : in_q.led_index;
		pa       = addr[AW-1:0];
		idx_ok   = in_q.led_index < IDX_W'(LED_COUNT);
		cur_code = codes_q[pa];
		pack_code = (IDX_W'(cnt_q) < IDX_W'(PACK_LEDS)) ?
			in_q.all_codes[SEL_W'(cnt_q) * SEL_W'(CODE_W) +: CODE_W] : CODE_OFF;
		phase    = (in_q.state_code == CODE_SLOW) ? slow_q : fast_q;
	end

	always_comb begin
		pin_we   = 1'b0;
		pin_val  = pins_q[pa];
		code_we  = 1'b0;
		code_val = in_q.state_code;
		off_d    = off_q;
		on_d     = on_q;
		flip     = 1'b0;
		if (cmd.exec && idx_ok) begin
			case (in_q.command)
				CMD_SET_ONE: begin
					pin_we  = 1'b1;
					pin_val = drive_level(in_q.state_code, pins_q[pa]);
					code_we = in_q.store_code;
				end
				CMD_FORCE_OFF: begin
					pin_we = 1'b1;
					if (in_q.force_flag) begin
						off_d[pa] = addr < IDX_W'(PIN_W);
						pin_val   = 1'b0;
					end else begin
						off_d[pa] = 1'b0;
						pin_val   = drive_level(cur_code, pins_q[pa]);
					end
				end
				CMD_FORCE_ON: begin
					pin_we = 1'b1;
					if (in_q.force_flag) begin
						on_d[pa] = addr < IDX_W'(PIN_W);
						pin_val  = 1'b1;
					end else begin
						on_d[pa] = 1'b0;
						pin_val  = drive_level(cur_code, pins_q[pa]);
					end
				end
				CMD_TOGGLE: begin
					pin_we  = 1'b1;
					pin_val = ~pins_q[pa];
				end
				default: begin
					pin_we = 1'b0;
				end
			endcase
		end
		if (cmd.walk) begin
			case (in_q.command)
				CMD_SET_ALL: begin
					pin_we   = 1'b1;
					pin_val  = drive_level(pack_code, pins_q[pa]);
					code_we  = 1'b1;
					code_val = pack_code;
				end
				CMD_TICK: begin
					if (cur_code == in_q.state_code && !off_q[pa]) begin
						pin_we  = 1'b1;
						pin_val = phase;
					end
					flip = sts.last;
				end
				default: begin
					pin_we = 1'b0;
				end
			endcase
		end
	end

	for (genvar n = 0; n < PIN_W; n++) begin : g_lvl
		if (n < LED_COUNT) begin : g_on
			assign levels[n] = pins_q[n];
		end else begin : g_off
			assign levels[n] = 1'b0;
		end
	end

	always_comb begin
		rb_code             = idx_ok ? cur_code : CODE_OFF;
		out_d.pin_levels    = levels;
		out_d.led_code_read = rb_code;
		out_d.state_matches = idx_ok && (rb_code == in_q.state_code);
	end

	always_comb begin
		sts.walk_cmd = (in_q.command == CMD_SET_ALL) ||
			((in_q.command == CMD_TICK) &&
			 ((in_q.state_code == CODE_SLOW) || (in_q.state_code == CODE_FAST)));
		sts.last     = cnt_q == AW'(LED_COUNT - 1);
		sts.out_free = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_word;
		end
		if (cmd.out_load) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				codes_q[i] <= CODE_OFF;
			end
			pins_q      <= '0;
			off_q       <= '0;
			on_q        <= '0;
			slow_q      <= 1'b1;
			fast_q      <= 1'b1;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pin_we) begin
				pins_q[pa] <= pin_val;
			end
			if (code_we) begin
				codes_q[pa] <= code_val;
			end
			off_q <= off_d;
			on_q  <= on_d;
			if (flip) begin
				if (in_q.state_code == CODE_SLOW) begin
					slow_q <= ~slow_q;
				end else begin
					fast_q <= ~fast_q;
				end
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.walk) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

>>> sv/led_state_blink_controller_core.sv
// LED state and blink controller core: top level, controller plus datapath.
// Single-LED commands: accept, execute, result load. Set all and slow or
// fast blink tick: accept, LED walk (one LED per walk cycle), result load.
// Result load waits for a free output; no new word is accepted until then.
// Reset: asynchronous; codes off, pins low, masks clear, both phases on.
module led_state_blink_controller_core #(
	parameter int LED_COUNT = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  lsbc_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output lsbc_pkg::out_word_t out_word
);
	import lsbc_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	lsbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsbc_dp #(
		.LED_COUNT (LED_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted word did not make the core busy");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.exec, cmd.walk, cmd.out_load}))
		else $error("controller issued overlapping commands");

	a_walk_only_for_walk_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> sts.walk_cmd)
		else $error("LED walk on a single-LED command");

endmodule

>>> tb/sv/led_state_blink_controller_core_test.sv
// Self-checking test of the LED state and blink controller core: a built-in LED model
// predicts each output word; directed and weighted random commands with random idling.
// Depends on lsbc_pkg and led_state_blink_controller_core.
module led_state_blink_controller_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lsbc_pkg::*;

	localparam int          LEDS       = 18;
	localparam logic [2:0]  CMD_UNUSED = 3'd7;
	localparam int          IDLE_LIMIT = 4000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;

	led_state_blink_controller_core #(.LED_COUNT(LEDS)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	always #1 clk = ~clk;

	in_word_t  pending_words[$];
	out_word_t expected_words[$];
	int        errors = 0;
	bit        calm = 1'b0;

	// LED model state
	logic [CODE_W-1:0] led_mode [LEDS];
	logic [LEDS-1:0]   pin_lvl;
	logic [LEDS-1:0]   off_mask;
	logic [LEDS-1:0]   on_mask;
	logic              slow_ph;
	logic              fast_ph;

	task automatic clear_leds();
		for (int n = 0; n < LEDS; n++) begin
			led_mode[n] = CODE_OFF;
		end
		pin_lvl  = '0;
		off_mask = '0;
		on_mask  = '0;
		slow_ph  = 1'b1;
		fast_ph  = 1'b1;
	endtask

	function automatic void pin_from_mode(input int n, input logic [CODE_W-1:0] mode);
		if (mode == CODE_ON) begin
			pin_lvl[n] = 1'b1;
		end else if (mode == CODE_OFF) begin
			pin_lvl[n] = 1'b0;
		end
	endfunction

	function automatic out_word_t next_led_word(input in_word_t w);
		out_word_t         r;
		logic              hit;
		logic              ph;
		logic [CODE_W-1:0] c;
		int                i;
		hit = w.led_index < LEDS;
		i = int'(w.led_index);
		case (w.command)
			CMD_SET_ONE: begin
				if (hit) begin
					pin_from_mode(i, w.state_code);
					if (w.store_code) begin
						led_mode[i] = w.state_code;
					end
				end
			end
			CMD_SET_ALL: begin
				for (int n = 0; n < LEDS; n++) begin
					c = (n < PACK_LEDS) ? w.all_codes[3*n +: 3] : CODE_OFF;
					pin_from_mode(n, c);
					led_mode[n] = c;
				end
			end
			CMD_FORCE_OFF: begin
				if (hit) begin
					off_mask[i] = w.force_flag;
					if (w.force_flag) begin
						pin_lvl[i] = 1'b0;
					end else begin
						pin_from_mode(i, led_mode[i]);
					end
				end
			end
			CMD_FORCE_ON: begin
				if (hit) begin
					on_mask[i] = w.force_flag;
					if (w.force_flag) begin
						pin_lvl[i] = 1'b1;
					end else begin
						pin_from_mode(i, led_mode[i]);
					end
				end
			end
			CMD_TOGGLE: begin
				if (hit) begin
					pin_lvl[i] = ~pin_lvl[i];
				end
			end
			CMD_TICK: begin
				if (w.state_code == CODE_SLOW || w.state_code == CODE_FAST) begin
					ph = (w.state_code == CODE_SLOW) ? slow_ph : fast_ph;
					for (int n = 0; n < LEDS; n++) begin
						if (led_mode[n] == w.state_code && !off_mask[n]) begin
							pin_lvl[n] = ph;
						end
					end
					if (w.state_code == CODE_SLOW) begin
						slow_ph = ~slow_ph;
					end else begin
						fast_ph = ~fast_ph;
					end
				end
			end
			default: ;
		endcase
		r.pin_levels    = pin_lvl[PIN_W-1:0];
		r.led_code_read = hit ? led_mode[i] : CODE_OFF;
		r.state_matches = hit && (led_mode[i] == w.state_code);
		return r;
	endfunction

	function automatic in_word_t make_word(input logic [2:0] cmd, input int idx,
			input logic [CODE_W-1:0] code, input logic st, input logic fr,
			input logic [PACK_W-1:0] codes);
		in_word_t w;
		w.command      = cmd;
		w.led_index    = IDX_W'(idx);
		w.state_code   = code;
		w.store_code   = st;
		w.force_flag   = fr;
		w.all_codes    = codes;
		return w;
	endfunction

	function automatic logic [CODE_W-1:0] pick_mode();
		case ($urandom_range(0, 9))
			0, 1:    return CODE_OFF;
			2, 3:    return CODE_SLOW;
			4, 5:    return CODE_FAST;
			6, 7:    return CODE_ON;
			default: return CODE_W'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		int       k;
		k = $urandom_range(0, 99);
		if (k < 20) w.command = CMD_SET_ONE;
		else if (k < 28) w.command = CMD_SET_ALL;
		else if (k < 40) w.command = CMD_FORCE_OFF;
		else if (k < 52) w.command = CMD_FORCE_ON;
		else if (k < 62) w.command = CMD_TOGGLE;
		else if (k < 84) w.command = CMD_TICK;
		else if (k < 97) w.command = CMD_READ;
		else w.command = CMD_UNUSED;
		w.led_index = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(18, 31))
		                                          : IDX_W'($urandom_range(0, 17));
		w.state_code = pick_mode();
		if (w.command == CMD_TICK && $urandom_range(0, 4) != 0) begin
			w.state_code = $urandom_range(0, 1) ? CODE_SLOW : CODE_FAST;
		end
		w.store_code   = 1'($urandom_range(0, 1));
		w.force_flag   = 1'($urandom_range(0, 1));
		for (k = 0; k < PACK_LEDS; k++) begin
			w.all_codes[3*k +: 3] = pick_mode();
		end
		return w;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		if (errors <= 40) begin
			$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
		end
	endtask

	// driver: one word per handshake, random idle bursts
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_words.push_back(next_led_word(in_word));
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_valid <= 1'b1;
					in_word  <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each output word, random stall bursts
	int stall_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report("unexpected word", 32'(out_word), 0);
				end else begin
					want = expected_words.pop_front();
					if (out_word.pin_levels !== want.pin_levels)
						report("pin_levels", 32'(out_word.pin_levels), 32'(want.pin_levels));
					if (out_word.led_code_read !== want.led_code_read)
						report("led_code_read", 32'(out_word.led_code_read),
						       32'(want.led_code_read));
					if (out_word.state_matches !== want.state_matches)
						report("state_matches", 32'(out_word.state_matches),
						       32'(want.state_matches));
				end
			end
			if (stall_gap > 0) begin
				stall_gap <= stall_gap - 1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_gap <= $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog: stop if busy and nothing moves for too long
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (pending_words.size() == 0 && expected_words.size() == 0 && !in_valid)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic drain();
		do @(negedge clk);
		while (pending_words.size() > 0 || expected_words.size() > 0 || in_valid);
	endtask

	initial begin
		logic [PACK_W-1:0] pattern;
		clear_leds();
		for (int n = 0; n < PACK_LEDS; n++) begin
			case (n % 4)
				0:       pattern[3*n +: 3] = CODE_OFF;
				1:       pattern[3*n +: 3] = CODE_SLOW;
				2:       pattern[3*n +: 3] = CODE_FAST;
				default: pattern[3*n +: 3] = CODE_ON;
			endcase
		end
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		pending_words.push_back(make_word(CMD_READ, 0, CODE_OFF, 0, 0, '0));
		pending_words.push_back(make_word(CMD_SET_ALL, 0, CODE_OFF, 0, 0, '1));
		pending_words.push_back(make_word(CMD_SET_ALL, 0, CODE_OFF, 0, 0, pattern));
		pending_words.push_back(make_word(CMD_SET_ONE, 17, CODE_SLOW, 1, 0, '0));
		pending_words.push_back(make_word(CMD_SET_ONE, 0, CODE_ON, 0, 0, '0));
		pending_words.push_back(make_word(CMD_SET_ONE, 31, CODE_ON, 1, 0, '0));
		pending_words.push_back(make_word(CMD_FORCE_OFF, 1, CODE_OFF, 0, 1, '0));
		pending_words.push_back(make_word(CMD_FORCE_ON, 2, CODE_OFF, 0, 1, '0));
		pending_words.push_back(make_word(CMD_TICK, 5, CODE_SLOW, 0, 0, '0));
		pending_words.push_back(make_word(CMD_TICK, 6, CODE_FAST, 0, 0, '0));
		pending_words.push_back(make_word(CMD_TICK, 17, CODE_SLOW, 0, 0, '0));
		pending_words.push_back(make_word(CMD_TICK, 0, CODE_OFF, 0, 0, '0));
		pending_words.push_back(make_word(CMD_TICK, 0, CODE_ON, 0, 0, '0));
		pending_words.push_back(make_word(CMD_FORCE_OFF, 1, CODE_OFF, 0, 0, '0));
		pending_words.push_back(make_word(CMD_FORCE_ON, 2, CODE_OFF, 0, 0, '0));
		pending_words.push_back(make_word(CMD_FORCE_OFF, 18, CODE_OFF, 0, 1, '0));
		pending_words.push_back(make_word(CMD_TOGGLE, 17, CODE_OFF, 0, 0, '0));
		pending_words.push_back(make_word(CMD_TOGGLE, 31, CODE_OFF, 0, 0, '0));
		pending_words.push_back(make_word(CMD_READ, 17, CODE_SLOW, 0, 0, '0));
		pending_words.push_back(make_word(CMD_READ, 25, CODE_OFF, 0, 0, '0));
		pending_words.push_back(make_word(CMD_UNUSED, 5, CODE_ON, 1, 1, '1));
		pending_words.push_back(make_word(CMD_SET_ALL, 0, CODE_OFF, 0, 0, '0));
		pending_words.push_back(make_word(CMD_READ, 3, CODE_ON, 0, 0, '0));
		drain();

		for (int k = 0; k < 1000; k++) pending_words.push_back(random_word());
		drain();
		for (int k = 0; k < 700; k++) pending_words.push_back(random_word());
		drain();
		calm = 1'b1;
		for (int k = 0; k < 300; k++) pending_words.push_back(random_word());
		drain();
		repeat (30) @(negedge clk);

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
